// ----- design/pfb_pkg.sv -----
// shared types, constants and helpers for the page frame occupancy bitmap
// no dependencies
`timescale 1ns / 1ps

package pfb_pkg;

  localparam int PAGE_COUNT = 4096;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W     = $clog2(WORD_COUNT);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int FUNC_W     = 3;
  localparam int PAGE_W     = 12;
  localparam int END_W      = 13;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_SET       = 3'd0,
    FN_CLEAR     = 3'd1,
    FN_TEST      = 3'd2,
    FN_FIND_FREE = 3'd3,
    FN_FIND_OCC  = 3'd4,
    FN_RANGE     = 3'd5
  } func_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } st_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PAGE_W-1:0] page;
    logic [END_W-1:0]  page_end;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [PAGE_W-1:0] found_page;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic finish;
  } sts_t;

  // index of the lowest set bit, zero when none
  function automatic logic [BIT_W-1:0] lowest_set(input word_t w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- design/pfb_dp.sv -----
// datapath: occupancy memory, word scan pointer, masks and result register
// depends on pfb_pkg
`timescale 1ns / 1ps

module pfb_dp import pfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  in_t  in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t out_data
);

  word_t             occ_mem_r [WORD_COUNT];
  logic [WORD_COUNT-1:0] vld_r;
  word_t             rd_data_r;
  logic              vld_rd_r;

  logic [FUNC_W-1:0] func_r;
  logic [WIDX_W-1:0] w_r;
  logic [WIDX_W-1:0] start_w_r;
  logic [BIT_W-1:0]  bit_r;
  logic              empty_r;
  logic [WIDX_W-1:0] last_w_r;
  logic [BIT_W-1:0]  end_bit_r;
  out_t              out_data_r;

  logic [WIDX_W-1:0] rd_addr;
  logic [END_W-1:0]  end_c;
  logic [END_W-1:0]  end_m1;
  word_t             word;
  word_t             lo_mask;
  word_t             hi_mask;
  word_t             cand;
  logic              found;
  logic              any_occ;
  logic              last_word;
  word_t             wr_word;
  out_t              res;

  // the word being looked at is read ahead so one word is examined per cycle
  always_comb begin
    if (cmd.load) begin
      rd_addr = in_data.page[PAGE_W-1 -: WIDX_W];
    end else if (cmd.step) begin
      rd_addr = w_r + WIDX_W'(1);
    end else begin
      rd_addr = w_r;
    end
  end

  // clamp range end to the top of the map
  always_comb begin
    end_c  = (in_data.page_end > END_W'(PAGE_COUNT)) ? END_W'(PAGE_COUNT) : in_data.page_end;
    end_m1 = end_c - END_W'(1);
  end

  always_ff @(posedge clk) begin
    rd_data_r <= occ_mem_r[rd_addr];
    if (cmd.commit && (func_r == FN_SET || func_r == FN_CLEAR)) begin
      occ_mem_r[w_r] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      vld_rd_r <= 1'b0;
    end else begin
      vld_rd_r <= vld_r[rd_addr];
      if (cmd.commit && (func_r == FN_SET || func_r == FN_CLEAR)) begin
        vld_r[w_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= in_data.func;
      start_w_r <= in_data.page[PAGE_W-1 -: WIDX_W];
      bit_r     <= in_data.page[BIT_W-1:0];
      empty_r   <= ({1'b0, in_data.page} >= end_c);
      last_w_r  <= end_m1[PAGE_W-1 -: WIDX_W];
      end_bit_r <= end_c[BIT_W-1:0];
    end
    if (cmd.load) begin
      w_r <= in_data.page[PAGE_W-1 -: WIDX_W];
    end else if (cmd.step) begin
      w_r <= w_r + WIDX_W'(1);
    end
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  always_comb begin
    word      = vld_rd_r ? rd_data_r : '0;
    lo_mask   = (w_r == start_w_r) ? ~((word_t'(1) << bit_r) - word_t'(1)) : '1;
    // an end on a word boundary leaves the whole last word in range
    hi_mask   = (w_r == last_w_r && end_bit_r != '0) ?
                ((word_t'(1) << end_bit_r) - word_t'(1)) : '1;
    cand      = ((func_r == FN_FIND_OCC) ? word : ~word) & lo_mask;
    found     = |cand;
    any_occ   = |(word & lo_mask & hi_mask);
    last_word = (w_r == WIDX_W'(WORD_COUNT - 1));
    wr_word   = word;
    wr_word[bit_r] = (func_r == FN_SET);
  end

  always_comb begin
    res        = '0;
    sts.finish = 1'b1;
    case (func_r)
      FN_TEST: begin
        res.hit = word[bit_r];
      end
      FN_FIND_FREE, FN_FIND_OCC: begin
        sts.finish = found || last_word;
        res.hit    = found;
        if (found) res.found_page = PAGE_W'({w_r, lowest_set(cand)});
      end
      FN_RANGE: begin
        sts.finish = empty_r || any_occ || (w_r == last_w_r);
        res.hit    = !empty_r && any_occ;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign out_data = out_data_r;

  a_step_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !last_word)
    else $error("scan stepped past the last word");

  a_step_unfinished: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !sts.finish && !cmd.commit)
    else $error("scan stepped on a settled request");

  a_commit_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.finish && !cmd.load)
    else $error("result taken from an unsettled request");

endmodule

// ----- design/pfb_ctrl.sv -----
// controller: request sequencing and result handshake
// depends on pfb_pkg
`timescale 1ns / 1ps

module pfb_ctrl import pfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  st_t  state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!sts.finish) begin
          cmd.step = 1'b1;
        end else if (!out_valid_r || out_ready) begin
          // result slot free: write back and hand over the word
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && state_r == ST_IDLE)
    else $error("committed result not presented");

  a_load_evals: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_EVAL && !cmd.load)
    else $error("accepted request not evaluated");

endmodule

// ----- design/page_frame_bitmap.sv -----
// Page frame occupancy bitmap, top level.
// Depends on pfb_pkg, pfb_ctrl and pfb_dp.
//
// One bit per page frame, 4096 pages in 64 words of 64 bits held in one
// memory. A request word on the in_ channel (func, page, page_end) marks a
// page occupied or free, tests it, finds the first free or occupied page at
// or after page, or tests a range [page, page_end) for any occupied page.
// Each request gives one result word (hit, found_page) on the out_ channel.
// One request is worked on at a time: in_ready is high only while idle.
// The datapath examines one bitmap word per cycle: set, clear and test visit
// one word; a find or range test visits the words from its start word to
// the word that settles it, 1 to 64. The controller returns to idle before
// the next request is taken. The result is written to the output register
// as the last word is examined, if the previous result has been taken.
// Results sit in an output register; the next request is accepted while it
// waits, and its result is held back only if the previous one is still not
// taken. Reset clears per-word valid flags so every page reads free
// immediately, with no clearing pass.
`timescale 1ns / 1ps

module page_frame_bitmap import pfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  cmd_t cmd;
  sts_t sts;

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
